@@ hdl/wasm_instruction_stream_decoder_unit_defines.svh @@
// Assertion macros for the wasm instruction stream decoder checker.
// No dependencies; include by bare file name.
`ifndef WASM_INSTRUCTION_STREAM_DECODER_UNIT_DEFINES_SVH
`define WASM_INSTRUCTION_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, held off during reset.
`define WISD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, clocked on clk_i, held off during reset.
`define WISD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/wisd_pkg.sv @@
// Package for the wasm instruction stream decoder: record type, kind codes.
// No dependencies.
`default_nettype none
package wisd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 4;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [KindW-1:0] KIND_NONE   = 4'd0;
  localparam logic [KindW-1:0] KIND_BYTE   = 4'd1;
  localparam logic [KindW-1:0] KIND_U32    = 4'd2;
  localparam logic [KindW-1:0] KIND_S32    = 4'd3;
  localparam logic [KindW-1:0] KIND_S64    = 4'd4;
  localparam logic [KindW-1:0] KIND_F32    = 4'd5;
  localparam logic [KindW-1:0] KIND_F64    = 4'd6;
  localparam logic [KindW-1:0] KIND_MEMARG = 4'd7;
  localparam logic [KindW-1:0] KIND_TARGET = 4'd8;

  typedef struct packed {
    logic [ByteW-1:0]   opcode;
    logic [KindW-1:0]   imm_kind;
    logic [ValueW-1:0]  imm_value;
    logic [OffsetW-1:0] mem_offset;
    logic               last_target;
    logic               error;
  } wisd_rec_t;

endpackage
`default_nettype wire

@@ hdl/wisd_if.sv @@
// Channel interfaces: code byte input and decoded record output.
// Depends on wisd_pkg.
`default_nettype none
interface wisd_byte_if import wisd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface wisd_rec_if import wisd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   opcode;
  logic [KindW-1:0]   imm_kind;
  logic [ValueW-1:0]  imm_value;
  logic [OffsetW-1:0] mem_offset;
  logic               last_target;
  logic               error;
  modport source (output valid, output opcode, output imm_kind, output imm_value,
                  output mem_offset, output last_target, output error, input ready);
  modport sink   (input valid, input opcode, input imm_kind, input imm_value,
                  input mem_offset, input last_target, input error, output ready);
endinterface
`default_nettype wire

@@ hdl/wisd_front.sv @@
// Front end: per-byte phase machine, LEB128/raw immediate accumulation.
// Depends on wisd_pkg.
`default_nettype none
module wisd_front import wisd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  push_o,
  output wisd_rec_t             rec_o
);

  localparam logic [3:0] PH_OPCODE    = 4'd0;
  localparam logic [3:0] PH_BYTE      = 4'd1;
  localparam logic [3:0] PH_RESERVED  = 4'd2;
  localparam logic [3:0] PH_INDEX     = 4'd3;
  localparam logic [3:0] PH_CI_TYPE   = 4'd4;
  localparam logic [3:0] PH_CI_TABLE  = 4'd5;
  localparam logic [3:0] PH_MA_ALIGN  = 4'd6;
  localparam logic [3:0] PH_MA_OFFSET = 4'd7;
  localparam logic [3:0] PH_BT_COUNT  = 4'd8;
  localparam logic [3:0] PH_BT_TARGET = 4'd9;
  localparam logic [3:0] PH_S32       = 4'd10;
  localparam logic [3:0] PH_S64       = 4'd11;
  localparam logic [3:0] PH_F32       = 4'd12;
  localparam logic [3:0] PH_F64       = 4'd13;

  localparam logic [6:0] Lim32 = 7'd35;
  localparam logic [6:0] Lim64 = 7'd70;

  logic [3:0]         phase_q, phase_d;
  logic [ByteW-1:0]   op_q, op_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [6:0]         shift_q, shift_d;
  logic [31:0]        align_q, align_d;
  logic [31:0]        left_q, left_d;

  function automatic logic [3:0] first_phase(input logic [7:0] op);
    logic [3:0] ph;
    ph = PH_OPCODE;
    if (op >= 8'h02 && op <= 8'h04) ph = PH_BYTE;
    else if (op == 8'h0C || op == 8'h0D || op == 8'h10) ph = PH_INDEX;
    else if (op == 8'h0E) ph = PH_BT_COUNT;
    else if (op == 8'h11) ph = PH_CI_TYPE;
    else if (op >= 8'h20 && op <= 8'h24) ph = PH_INDEX;
    else if (op >= 8'h28 && op <= 8'h3E) ph = PH_MA_ALIGN;
    else if (op == 8'h3F || op == 8'h40) ph = PH_RESERVED;
    else if (op == 8'h41) ph = PH_S32;
    else if (op == 8'h42) ph = PH_S64;
    else if (op == 8'h43) ph = PH_F32;
    else if (op == 8'h44) ph = PH_F64;
    return ph;
  endfunction

  logic [6:0]        nshift;
  logic [ValueW-1:0] leb_acc, raw_acc, s64_val;
  logic [31:0]       s32_val;
  logic              more, fail32, fail64, done;

  always_comb begin
    nshift  = shift_q + 7'd7;
    leb_acc = acc_q;
    if (shift_q < 7'd64) leb_acc = acc_q | ({57'd0, byte_i[6:0]} << shift_q[5:0]);
    raw_acc = acc_q | ({56'd0, byte_i} << shift_q[5:0]);
    more    = byte_i[7];
    done    = !more;
    fail32  = more && (nshift >= Lim32);
    fail64  = more && (nshift >= Lim64);
    s32_val = leb_acc[31:0];
    if (nshift < 7'd32 && byte_i[6]) s32_val = s32_val | (32'hFFFF_FFFF << nshift[4:0]);
    s64_val = leb_acc;
    if (nshift < 7'd64 && byte_i[6]) s64_val = s64_val | ({ValueW{1'b1}} << nshift[5:0]);
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    acc_d   = acc_q;
    shift_d = shift_q;
    align_d = align_q;
    left_d  = left_q;
    push_o  = 1'b0;
    rec_o   = '{opcode: op_q, imm_kind: KIND_NONE, imm_value: '0, mem_offset: '0,
                last_target: 1'b1, error: 1'b0};
    if (take_i) begin
      // leb phases: accumulate by default, overridden on finish below
      acc_d   = leb_acc;
      shift_d = nshift;
      case (phase_q)
        PH_BYTE: begin
          push_o = 1'b1;
          rec_o.imm_kind  = KIND_BYTE;
          rec_o.imm_value = {56'd0, byte_i};
        end
        PH_RESERVED: push_o = 1'b1;
        PH_INDEX, PH_CI_TABLE: begin
          rec_o.imm_kind = KIND_U32;
          if (fail32) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            push_o = 1'b1;
            rec_o.imm_value = (phase_q == PH_INDEX) ? {32'd0, leb_acc[31:0]}
                                                     : {32'd0, align_q};
          end
        end
        PH_CI_TYPE, PH_MA_ALIGN, PH_BT_COUNT: begin
          rec_o.imm_kind = (phase_q == PH_CI_TYPE) ? KIND_U32 :
                           (phase_q == PH_MA_ALIGN) ? KIND_MEMARG : KIND_TARGET;
          if (fail32) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            acc_d   = '0;
            shift_d = '0;
            if (phase_q == PH_BT_COUNT) begin
              left_d  = leb_acc[31:0];
              phase_d = PH_BT_TARGET;
            end else begin
              align_d = leb_acc[31:0];
              phase_d = (phase_q == PH_CI_TYPE) ? PH_CI_TABLE : PH_MA_OFFSET;
            end
          end
        end
        PH_MA_OFFSET: begin
          rec_o.imm_kind = KIND_MEMARG;
          if (fail32) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            push_o = 1'b1;
            rec_o.imm_value  = {32'd0, align_q};
            rec_o.mem_offset = leb_acc[31:0];
          end
        end
        PH_BT_TARGET: begin
          rec_o.imm_kind = KIND_TARGET;
          if (fail32) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            push_o = 1'b1;
            rec_o.imm_value = {32'd0, leb_acc[31:0]};
            if (left_q != 32'd0) begin
              rec_o.last_target = 1'b0;
              left_d = left_q - 32'd1;
            end
          end
        end
        PH_S32: begin
          rec_o.imm_kind = KIND_S32;
          if (fail32) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            push_o = 1'b1;
            rec_o.imm_value = {{32{s32_val[31]}}, s32_val};
          end
        end
        PH_S64: begin
          rec_o.imm_kind = KIND_S64;
          if (fail64) begin
            push_o = 1'b1;
            rec_o.error = 1'b1;
          end else if (done) begin
            push_o = 1'b1;
            rec_o.imm_value = s64_val;
          end
        end
        PH_F32, PH_F64: begin
          acc_d   = raw_acc;
          shift_d = shift_q + 7'd8;
          rec_o.imm_kind  = (phase_q == PH_F32) ? KIND_F32 : KIND_F64;
          rec_o.imm_value = raw_acc;
          push_o = (phase_q == PH_F32) ? (shift_d >= 7'd32) : (shift_d >= 7'd64);
        end
        default: begin
          // opcode phase (and unused codes, which act as a reset)
          op_d    = byte_i;
          acc_d   = '0;
          shift_d = '0;
          phase_d = first_phase(byte_i);
          rec_o.opcode = byte_i;
          push_o = (phase_d == PH_OPCODE);
          if (phase_q != PH_OPCODE) begin
            align_d = '0;
            left_d  = '0;
          end
        end
      endcase
      if (push_o) begin
        // a non-final br_table target keeps parsing targets
        phase_d = rec_o.last_target ? PH_OPCODE : PH_BT_TARGET;
        acc_d   = '0;
        shift_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      op_q    <= '0;
      acc_q   <= '0;
      shift_q <= '0;
      align_q <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      acc_q   <= acc_d;
      shift_q <= shift_d;
      align_q <= align_d;
      left_q  <= left_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/wisd_queue.sv @@
// Short record queue between front and back ends.
// Depends on wisd_pkg.
`default_nettype none
module wisd_queue import wisd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wisd_rec_t      rec_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output wisd_rec_t      rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wisd_rec_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/wisd_back.sv @@
// Back end: output register that drains the queue onto the record channel.
// Depends on wisd_pkg.
`default_nettype none
module wisd_back import wisd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  avail_i,
  input  wisd_rec_t  rec_i,
  output logic       pop_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output wisd_rec_t  out_rec_o
);

  logic      valid_q, valid_d;
  wisd_rec_t rec_q;

  assign pop_o       = avail_i && (!valid_q || out_ready_i);
  assign valid_d     = pop_o || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

endmodule
`default_nettype wire

@@ hdl/wasm_instruction_stream_decoder_unit.sv @@
// Throughput: one code byte per cycle, sustained; input stalls only when the queue fills.
// Path: a record is written into the queue by the byte that ends its instruction, then moves
//   into the output register.
// Reset: asynchronous active-low; parser returns to the opcode phase, queue and output empty.
// Depends on wisd_pkg, wisd_if, wisd_front, wisd_queue, wisd_back.
`default_nettype none
module wasm_instruction_stream_decoder_unit import wisd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wisd_byte_if.sink  in_i,
  wisd_rec_if.source out_o
);

  // Front: consumes a byte per transaction and emits at most one record.
  logic      q_full, q_valid, push, pop;
  wisd_rec_t front_rec, q_rec, out_rec;
  logic      take;

  // Queue space is the only thing that holds the input off.
  assign in_i.ready = !q_full;
  assign take       = in_i.valid && !q_full;

  wisd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.code_byte),
    .push_o (push),
    .rec_o  (front_rec)
  );

  // Decoupling queue: front keeps parsing while the sink stalls, until the queue fills.
  wisd_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  // Back: registered output transaction.
  wisd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_valid),
    .rec_i       (q_rec),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_rec_o   (out_rec)
  );

  assign out_o.opcode      = out_rec.opcode;
  assign out_o.imm_kind    = out_rec.imm_kind;
  assign out_o.imm_value   = out_rec.imm_value;
  assign out_o.mem_offset  = out_rec.mem_offset;
  assign out_o.last_target = out_rec.last_target;
  assign out_o.error       = out_rec.error;

endmodule
`default_nettype wire

@@ hdl/wisd_checker.sv @@
// Port-level checker for the decoder top level, plus its bind.
// Depends on wisd_pkg and wasm_instruction_stream_decoder_unit_defines.svh.
`default_nettype none
`include "wasm_instruction_stream_decoder_unit_defines.svh"
module wisd_checker import wisd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [KindW-1:0]   imm_kind_i,
  input wire logic [ValueW-1:0]  imm_value_i,
  input wire logic [OffsetW-1:0] mem_offset_i,
  input wire logic               last_target_i,
  input wire logic               error_i
);

  `WISD_ASSERT_NXT(a_hold_valid, out_valid_i && !out_ready_i, out_valid_i)
  `WISD_ASSERT_IMP(a_err_clean, out_valid_i && error_i,
                   imm_value_i == '0 && mem_offset_i == '0 && last_target_i)
  `WISD_ASSERT_IMP(a_offset_memarg, out_valid_i && imm_kind_i != KIND_MEMARG, mem_offset_i == '0)
  `WISD_ASSERT_IMP(a_partial_target, out_valid_i && !last_target_i, imm_kind_i == KIND_TARGET)

endmodule

bind wasm_instruction_stream_decoder_unit wisd_checker u_wisd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .imm_kind_i    (out_o.imm_kind),
  .imm_value_i   (out_o.imm_value),
  .mem_offset_i  (out_o.mem_offset),
  .last_target_i (out_o.last_target),
  .error_i       (out_o.error)
);
`default_nettype wire

@@ dv/tb_wasm_instruction_stream_decoder_unit.sv @@
// Self-checking testbench for the wasm instruction stream decoder unit.
// Depends on wisd_pkg, wisd_if and the RTL of wasm_instruction_stream_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_wasm_instruction_stream_decoder_unit;
  import wisd_pkg::*;

  // Parser phases of the local decode model.
  typedef enum logic [3:0] {
    PH_OPCODE, PH_BYTE, PH_RESERVED, PH_INDEX, PH_CI_TYPE, PH_CI_TABLE,
    PH_MA_ALIGN, PH_MA_OFFSET, PH_BT_COUNT, PH_BT_TARGET, PH_S32, PH_S64,
    PH_F32, PH_F64
  } dec_phase_e;

  typedef enum int { LEB_MORE, LEB_DONE, LEB_FAIL } leb_res_e;

  // Opcodes used by the stimulus.
  localparam logic [7:0] OP_NOP      = 8'h01;
  localparam logic [7:0] OP_BLOCK    = 8'h02;
  localparam logic [7:0] OP_BR       = 8'h0C;
  localparam logic [7:0] OP_BR_TABLE = 8'h0E;
  localparam logic [7:0] OP_CALL     = 8'h10;
  localparam logic [7:0] OP_CALL_IND = 8'h11;
  localparam logic [7:0] OP_LOCAL_GET = 8'h20;
  localparam logic [7:0] OP_LOAD     = 8'h28;
  localparam logic [7:0] OP_MEM_SIZE = 8'h3F;
  localparam logic [7:0] OP_I32_CONST = 8'h41;
  localparam logic [7:0] OP_I64_CONST = 8'h42;
  localparam logic [7:0] OP_F32_CONST = 8'h43;
  localparam logic [7:0] OP_F64_CONST = 8'h44;

  localparam int RandBytes   = 1200;
  localparam int WdogLimit   = 5000;
  localparam int LongHold    = 80;
  localparam int MaxReported = 10;

  logic clk_i;
  logic rst_ni;

  wisd_byte_if in_if ();
  wisd_rec_if  out_if ();

  wasm_instruction_stream_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // ---------------------------------------------------------------------------
  // Decode model state (mirror of the parser)
  // ---------------------------------------------------------------------------
  dec_phase_e  m_phase;
  logic [7:0]  m_opcode;
  logic [63:0] m_acc;
  int unsigned m_shift;
  logic [31:0] m_align;
  logic [31:0] m_targets_left;

  wisd_rec_t   exp_rec_q[$];   // decoded records still owed by the DUT

  int n_bytes, n_recs, n_errs, n_targets, n_mismatch;
  int send_idle_pct, recv_stall_pct;
  int hold_req;                 // long receiver hold-off, counted by the sink

  function automatic wisd_rec_t mk_rec(logic [7:0] op, logic [3:0] kind, logic [63:0] val,
                                       logic [31:0] off, logic last, logic err);
    wisd_rec_t r;
    r.opcode = op; r.imm_kind = kind; r.imm_value = val;
    r.mem_offset = off; r.last_target = last; r.error = err;
    return r;
  endfunction

  function automatic void field_start(dec_phase_e nxt);
    m_phase = nxt;
    m_acc   = '0;
    m_shift = 0;
  endfunction

  function automatic leb_res_e leb_feed(logic [7:0] b, int unsigned limit);
    if (m_shift < 64) m_acc |= 64'(b[6:0]) << m_shift;
    m_shift += 7;
    if (!b[7]) return LEB_DONE;
    if (m_shift >= limit) return LEB_FAIL;
    return LEB_MORE;
  endfunction

  function automatic void opcode_start(logic [7:0] op);
    m_opcode = op;
    if (op >= 8'h02 && op <= 8'h04) field_start(PH_BYTE);
    else if (op == OP_BR || op == 8'h0D || op == OP_CALL) field_start(PH_INDEX);
    else if (op == OP_BR_TABLE) field_start(PH_BT_COUNT);
    else if (op == OP_CALL_IND) field_start(PH_CI_TYPE);
    else if (op >= 8'h20 && op <= 8'h24) field_start(PH_INDEX);
    else if (op >= 8'h28 && op <= 8'h3E) field_start(PH_MA_ALIGN);
    else if (op == 8'h3F || op == 8'h40) field_start(PH_RESERVED);
    else if (op == OP_I32_CONST) field_start(PH_S32);
    else if (op == OP_I64_CONST) field_start(PH_S64);
    else if (op == OP_F32_CONST) field_start(PH_F32);
    else if (op == OP_F64_CONST) field_start(PH_F64);
    else field_start(PH_OPCODE);
  endfunction

  // Advance the model by one byte; returns 1 with the record it produces.
  function automatic bit decode_byte(logic [7:0] b, output wisd_rec_t r);
    leb_res_e    lr;
    logic [31:0] v32;
    logic [63:0] v64;
    bit          hit;
    hit = 1'b0;
    r   = '0;
    case (m_phase)
      PH_OPCODE: begin
        opcode_start(b);
        if (m_phase == PH_OPCODE) begin
          r = mk_rec(m_opcode, KIND_NONE, 0, 0, 1, 0); hit = 1;
        end
      end
      PH_BYTE: begin
        r = mk_rec(m_opcode, KIND_BYTE, 64'(b), 0, 1, 0); hit = 1;
      end
      PH_RESERVED: begin
        r = mk_rec(m_opcode, KIND_NONE, 0, 0, 1, 0); hit = 1;
      end
      PH_INDEX, PH_CI_TABLE: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_U32, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          v64 = (m_phase == PH_INDEX) ? 64'(m_acc[31:0]) : 64'(m_align);
          r = mk_rec(m_opcode, KIND_U32, v64, 0, 1, 0); hit = 1;
        end
      end
      PH_CI_TYPE, PH_MA_ALIGN: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, (m_phase == PH_CI_TYPE) ? KIND_U32 : KIND_MEMARG, 0, 0, 1, 1);
          hit = 1;
        end else if (lr == LEB_DONE) begin
          m_align = m_acc[31:0];
          field_start((m_phase == PH_CI_TYPE) ? PH_CI_TABLE : PH_MA_OFFSET);
        end
      end
      PH_MA_OFFSET: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_MEMARG, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          r = mk_rec(m_opcode, KIND_MEMARG, 64'(m_align), m_acc[31:0], 1, 0); hit = 1;
        end
      end
      PH_BT_COUNT: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_TARGET, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          m_targets_left = m_acc[31:0];
          field_start(PH_BT_TARGET);
        end
      end
      PH_BT_TARGET: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_TARGET, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          // default target closes the instruction; earlier ones keep the phase
          r = mk_rec(m_opcode, KIND_TARGET, 64'(m_acc[31:0]), 0, m_targets_left == 0, 0);
          hit = 1;
          if (m_targets_left != 0) begin
            m_targets_left--;
            field_start(PH_BT_TARGET);
            return hit;
          end
        end
      end
      PH_S32: begin
        lr = leb_feed(b, 35);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_S32, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          v32 = m_acc[31:0];
          // sign bit only extends when the value is shorter than the width
          if (m_shift < 32 && b[6]) v32 |= 32'hFFFF_FFFF << m_shift;
          r = mk_rec(m_opcode, KIND_S32, {{32{v32[31]}}, v32}, 0, 1, 0); hit = 1;
        end
      end
      PH_S64: begin
        lr = leb_feed(b, 70);
        if (lr == LEB_FAIL) begin
          r = mk_rec(m_opcode, KIND_S64, 0, 0, 1, 1); hit = 1;
        end else if (lr == LEB_DONE) begin
          v64 = m_acc;
          if (m_shift < 64 && b[6]) v64 |= {64{1'b1}} << m_shift;
          r = mk_rec(m_opcode, KIND_S64, v64, 0, 1, 0); hit = 1;
        end
      end
      PH_F32, PH_F64: begin
        m_acc |= 64'(b) << (m_shift & 63);
        m_shift += 8;
        if (m_phase == PH_F32 && m_shift >= 32) begin
          r = mk_rec(m_opcode, KIND_F32, m_acc, 0, 1, 0); hit = 1;
        end else if (m_phase == PH_F64 && m_shift >= 64) begin
          r = mk_rec(m_opcode, KIND_F64, m_acc, 0, 1, 0); hit = 1;
        end
      end
      default: field_start(PH_OPCODE);
    endcase
    if (hit) field_start(PH_OPCODE);
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one transaction per call, valid drops during random idle gaps between calls
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit typed, wisd_rec_t typed_rec);
    wisd_rec_t r;
    bit        hit;
    in_if.valid     <= 1'b1;
    in_if.code_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    hit = decode_byte(b, r);
    n_bytes++;
    // directed rows with a hand-written result replace the model's one
    if (typed) exp_rec_q = {exp_rec_q, typed_rec};
    else if (hit) exp_rec_q = {exp_rec_q, r};
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_records();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (exp_rec_q.size() == 0);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: check every record transaction, then pick next ready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    wisd_rec_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = mk_rec(out_if.opcode, out_if.imm_kind, out_if.imm_value, out_if.mem_offset,
                   out_if.last_target, out_if.error);
      if (exp_rec_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxReported)
          $display("ERROR: unexpected record %h", got);
      end else begin
        want = exp_rec_q.pop_front();
        n_recs++;
        if (got.error) n_errs++;
        if (got.imm_kind == KIND_TARGET) n_targets++;
        if (got.opcode !== want.opcode || got.imm_kind !== want.imm_kind ||
            got.imm_value !== want.imm_value || got.mem_offset !== want.mem_offset ||
            got.last_target !== want.last_target || got.error !== want.error) begin
          n_mismatch++;
          if (n_mismatch <= MaxReported)
            $display("ERROR: record mismatch exp %h got %h", want, got);
        end
      end
    end
    if (hold_req > 0) begin
      hold_req     <= hold_req - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: cycles without any transaction on either channel.
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("wasm_instruction_stream_decoder_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random instruction generation
  // ---------------------------------------------------------------------------
  logic [7:0] gen_q[$];

  task automatic put_byte(logic [7:0] b);
    gen_q = {gen_q, b};
  endtask

  // LEB of nbytes groups; overlong keeps the continuation bit past the limit.
  task automatic push_leb(logic [63:0] val, int nbytes, bit overlong, int maxb);
    int i;
    logic [6:0] grp;
    if (overlong) nbytes = maxb + 1;
    for (i = 0; i < nbytes; i++) begin
      grp = 7'(val >> (7 * i));
      put_byte({(i != nbytes - 1), grp});
    end
  endtask

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // half of the values shifted right (some then inverted) so that magnitudes vary
    case ($urandom_range(3))
      0: v = v >> $urandom_range(63);
      1: v = ~(v >> $urandom_range(63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic gen_instr();
    int i, cnt;
    bit ovl;
    ovl = ($urandom_range(19) == 0);
    case ($urandom_range(12))
      0: put_byte(8'($urandom_range(8'h45, 8'hFF)));
      1: begin put_byte(8'(OP_BLOCK + $urandom_range(2))); put_byte(8'($urandom)); end
      2: begin
        put_byte($urandom_range(1) ? OP_BR : 8'(OP_LOCAL_GET + $urandom_range(4)));
        push_leb(rnd64(), $urandom_range(5, 1), ovl, 5);
      end
      3: begin
        put_byte(OP_CALL_IND);
        push_leb(rnd64(), $urandom_range(5, 1), ovl && $urandom_range(1), 5);
        push_leb(rnd64(), $urandom_range(5, 1), ovl, 5);
      end
      4: begin
        put_byte(8'(OP_LOAD + $urandom_range(22)));
        push_leb(rnd64(), $urandom_range(5, 1), ovl && $urandom_range(1), 5);
        push_leb(rnd64(), $urandom_range(5, 1), ovl, 5);
      end
      5: begin put_byte(8'(OP_MEM_SIZE + $urandom_range(1))); put_byte(8'($urandom)); end
      6: begin put_byte(OP_I32_CONST); push_leb(rnd64(), $urandom_range(5, 1), ovl, 5); end
      7: begin put_byte(OP_I64_CONST); push_leb(rnd64(), $urandom_range(10, 1), ovl, 10); end
      8: begin put_byte(OP_F32_CONST); repeat (4) put_byte(8'($urandom)); end
      9: begin put_byte(OP_F64_CONST); repeat (8) put_byte(8'($urandom)); end
      10: begin
        cnt = $urandom_range(4);
        put_byte(OP_BR_TABLE);
        push_leb(64'(cnt), $urandom_range(3, 1), 1'b0, 5);
        for (i = 0; i <= cnt; i++)
          push_leb(rnd64(), $urandom_range(5, 1), ovl && (i == cnt), 5);
      end
      11: put_byte(8'($urandom));  // noise
      default: put_byte(OP_NOP);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] b;
    bit         typed;
    wisd_rec_t  rec;
  } dir_row_t;

  dir_row_t dir_tab[$];

  task automatic row(logic [7:0] b, bit typed = 0, wisd_rec_t rec = '0);
    dir_row_t dr;
    dr = '{b, typed, rec};
    dir_tab = {dir_tab, dr};
  endtask

  initial begin
    int k, phase_n;
    in_if.valid     = 1'b0;
    in_if.code_byte = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    n_bytes = 0; n_recs = 0; n_errs = 0; n_targets = 0; n_mismatch = 0;
    hold_req = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    field_start(PH_OPCODE);
    m_opcode = '0; m_align = '0; m_targets_left = '0;

    // plain opcodes at both ends of the byte range
    row(OP_NOP, 1, mk_rec(OP_NOP, KIND_NONE, 0, 0, 1, 0));
    row(8'hFF,  1, mk_rec(8'hFF, KIND_NONE, 0, 0, 1, 0));
    row(8'h00,  1, mk_rec(8'h00, KIND_NONE, 0, 0, 1, 0));
    // block type byte
    row(OP_BLOCK); row(8'h40, 1, mk_rec(OP_BLOCK, KIND_BYTE, 64'h40, 0, 1, 0));
    // overlong index: fifth byte still continues
    row(OP_LOCAL_GET); repeat (4) row(8'h80);
    row(8'h80, 1, mk_rec(OP_LOCAL_GET, KIND_U32, 0, 0, 1, 1));
    // i32.const -1, sign taken from 0x40
    row(OP_I32_CONST); row(8'h7F, 1, mk_rec(OP_I32_CONST, KIND_S32, '1, 0, 1, 0));
    // reserved byte skipped, value unchecked
    row(OP_MEM_SIZE); row(8'hAA, 1, mk_rec(OP_MEM_SIZE, KIND_NONE, 0, 0, 1, 0));
    // empty br_table: only the default record
    row(OP_BR_TABLE); row(8'h00); row(8'h05, 1, mk_rec(OP_BR_TABLE, KIND_TARGET, 5, 0, 1, 0));
    // br_table with one target, call_indirect, memarg
    row(OP_BR_TABLE); row(8'h01); row(8'h7F); row(8'h00);
    row(OP_CALL_IND); row(8'h83); row(8'h01); row(8'h00);
    row(OP_LOAD); row(8'h02); row(8'h10);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].rec);
    drain_records();

    // random part in three idling regimes
    for (phase_n = 0; phase_n < 3; phase_n++) begin
      send_idle_pct  = (phase_n == 0) ? 24 : (phase_n == 1) ? 60 : 0;
      recv_stall_pct = (phase_n == 0) ? 60 : (phase_n == 1) ? 24 : 0;
      // fill the output path with the sink held off
      if (phase_n == 2) hold_req = LongHold;
      k = 0;
      while (k < RandBytes / 3) begin
        gen_instr();
        while (gen_q.size() > 0) begin
          send_byte(gen_q.pop_front(), 1'b0, '0);
          k++;
        end
      end
      // sender waits for every owed record before the next regime
      drain_records();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d code bytes, %0d records (%0d LEB errors, %0d branch targets).",
             n_bytes, n_recs, n_errs, n_targets);
    if (n_mismatch == 0 && exp_rec_q.size() == 0) begin
      $display("wasm_instruction_stream_decoder_unit test passed");
    end else begin
      $display("%0d mismatches, %0d records missing", n_mismatch, exp_rec_q.size());
      $display("wasm_instruction_stream_decoder_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/wisd_pkg.sv
hdl/wisd_if.sv
hdl/wisd_front.sv
hdl/wisd_queue.sv
hdl/wisd_back.sv
hdl/wasm_instruction_stream_decoder_unit.sv
hdl/wisd_checker.sv
dv/tb_wasm_instruction_stream_decoder_unit.sv
